// ===== hdl/inverted_blur5x5_rgb_stream_defines.svh =====
// Assertion macros for the blur stream block.
`ifndef INVERTED_BLUR5X5_RGB_STREAM_DEFINES_SVH
`define INVERTED_BLUR5X5_RGB_STREAM_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define IBL_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define IBL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IBL_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define IBL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hdl/ibl_pkg.sv =====
package ibl_pkg;
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;

   localparam logic [11:0] WIDTH_RST  = 12'd640;
   localparam logic [12:0] HEIGHT_RST = 13'd480;

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic CMD_PIXEL = 1'b0;

   // floor(s/35) == (s * RECIP_35) >> 20 for s <= 8925
   localparam logic [28:0] RECIP_35 = 29'd29960;

   typedef logic [23:0] pix_type;
   typedef logic [2:0][11:0] col_sum_type;

   typedef struct packed {
      logic adv;
      logic shift;
      logic clr;
   } win_ctl_type;
endpackage

// ===== hdl/ibl_line_store.sv =====
module ibl_line_store import ibl_pkg::*; (
   input  logic             clock,
   input  logic             wr_en,
   input  logic             rd_en,
   input  logic [COL_W-1:0] addr,
   input  pix_type          wdata,
   output pix_type          rdata
);
   pix_type mem [MAX_WIDTH];
   pix_type rdata_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
      if (wr_en) begin
         mem[addr] <= wdata;
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== hdl/ibl_col_cell.sv =====
module ibl_col_cell import ibl_pkg::*; (
   input  logic              clock,
   input  win_ctl_type       ctl,
   input  logic [1:0]        wt_mid,
   input  logic [1:0]        wt_ctr,
   input  pix_type [4:0]     din,
   output pix_type [4:0]     dout,
   output col_sum_type       sum
);
   pix_type [4:0] col_ff, col_in;
   col_sum_type   sum_ff, sum_in;

   always_comb begin
      col_in = col_ff;
      if (ctl.shift) begin
         col_in = ctl.clr ? '0 : din;
      end
      for (int k = 0; k < 3; k++) begin
         sum_in[k] = 12'(col_ff[0][8*k +: 8]) + 12'(col_ff[4][8*k +: 8])
                   + 12'(col_ff[1][8*k +: 8]) * 12'(wt_mid)
                   + 12'(col_ff[3][8*k +: 8]) * 12'(wt_mid)
                   + 12'(col_ff[2][8*k +: 8]) * 12'(wt_ctr);
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
      if (ctl.adv) begin
         sum_ff <= sum_in;
      end
   end

   assign dout = col_ff;
   assign sum  = sum_ff;
endmodule

// ===== hdl/inverted_blur5x5_rgb_stream.sv =====
// channel | dir | handshake            | payload
// req     | in  | req_tvalid/tready    | tdata: blue, green, red; tuser: command
// rsp     | out | rsp_tvalid/tready    | tdata: blue, green, red; tlast; tuser
// csr     | in  | csr_wr_en            | csr_index, csr_wdata
// One word per cycle unless rsp stalls; a word that ends a row holds the input
// while the two trailing zero columns of the row shift through the window.
// A result is registered at the line store read, then in the window, column
// sums, total, and after the divide in the output register.
// Synchronous active-high reset loads the size defaults and clears control and
// valid flags; data and line stores stay. A stalled rsp freezes the whole pipeline.
`include "inverted_blur5x5_rgb_stream_defines.svh"
module inverted_blur5x5_rgb_stream import ibl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // blue[7:0], green[15:8], red[23:16]
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // blue[7:0], green[15:8], red[23:16]
   output logic        rsp_tlast,
   output logic        rsp_tuser,   // frame_last
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [12:0] csr_wdata
);
   logic [11:0] width_ff, width_in;
   logic [12:0] height_ff, height_in;
   logic [11:0] w_eff;
   logic [12:0] h_eff;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  width_in  = csr_wdata[11:0];
            REG_FRAME_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
      w_eff = (width_ff == '0) ? 12'd1 :
              (width_ff > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : width_ff;
      h_eff = (height_ff == '0) ? 13'd1 :
              (height_ff > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : height_ff;
   end

   // position and input stage
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             acc, adv, take_b;
   logic             end_row, end_frame, rows_ok;
   pix_type          val;
   logic [3:0]       kv;
   pix_type [3:0]    rd;

   assign acc = req_tvalid & req_tready;

   always_comb begin
      end_row   = (12'(col_ff) + 12'd1) >= w_eff;
      end_frame = end_row && ((14'(row_ff) + 14'd1) >= (14'(h_eff) + 14'd2));
      rows_ok   = (row_ff >= 13'd2) && ((row_ff - 13'd2) < h_eff);
      val       = (req_tuser == CMD_PIXEL && row_ff < h_eff) ? req_tdata : '0;
      for (int i = 0; i < 4; i++) begin
         kv[i] = ((14'(row_ff) + 14'(i)) >= 14'd4) &&
                 ((14'(row_ff) + 14'(i)) < (14'(h_eff) + 14'd4));
      end
      col_in = col_ff;
      row_in = row_ff;
      if (acc) begin
         if (end_row) begin
            col_in = '0;
            row_in = end_frame ? '0 : row_ff + 13'd1;
         end else begin
            col_in = col_ff + 11'd1;
         end
      end
   end

   for (genvar j = 0; j < 4; j++) begin : g_line
      ibl_line_store u_line (
         .clock (clock),
         .wr_en (acc && (row_ff[1:0] == 2'(j))),
         .rd_en (acc),
         .addr  (col_ff),
         .wdata (val),
         .rdata (rd[j])
      );
   end

   // read stage
   logic       b_vld_ff, b_vld_in;
   pix_type    b_val_ff;
   logic [3:0] b_kv_ff;
   logic [1:0] b_rsel_ff;
   logic       b_clr_ff, b_e0_ff, b_e1_ff, b_e2_ff, b_er_ff, b_ef_ff;

   // trailing zero shifts at row end
   logic [1:0] pend_ff, pend_in;
   logic       q_e1_ff, q_e2_ff, q_ef_ff;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign take_b     = adv && pend_ff == 2'd0 && b_vld_ff;
   assign req_tready = adv && (pend_ff == 2'd0 || !b_vld_ff);

   always_comb begin
      b_vld_in = acc ? 1'b1 : (take_b ? 1'b0 : b_vld_ff);
      pend_in  = pend_ff;
      if (adv) begin
         if (take_b) begin
            pend_in = b_er_ff ? 2'd2 : 2'd0;
         end else if (pend_ff != 2'd0) begin
            pend_in = pend_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         col_ff    <= '0;
         row_ff    <= '0;
         b_vld_ff  <= 1'b0;
         pend_ff   <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         b_vld_ff  <= b_vld_in;
         pend_ff   <= pend_in;
      end
      if (acc) begin
         b_val_ff  <= val;
         b_kv_ff   <= kv;
         b_rsel_ff <= row_ff[1:0];
         b_clr_ff  <= col_ff == '0;
         b_e0_ff   <= rows_ok && col_ff >= 11'd2;
         b_e1_ff   <= rows_ok && col_ff >= 11'd1;
         b_e2_ff   <= rows_ok;
         b_er_ff   <= end_row;
         b_ef_ff   <= end_frame;
      end
      if (take_b) begin
         q_e1_ff <= b_e1_ff;
         q_e2_ff <= b_e2_ff;
         q_ef_ff <= b_ef_ff;
      end
   end

   // window: chain of column cells, cell 0 oldest
   win_ctl_type            wctl;
   pix_type [4:0]          newcol;
   pix_type [5:0][4:0]     chain;
   col_sum_type [4:0]      csum;
   logic [4:0][1:0]        wt_mid, wt_ctr;

   always_comb begin
      wctl.adv   = adv;
      wctl.shift = adv && (take_b || pend_ff != 2'd0);
      wctl.clr   = take_b && b_clr_ff;
      for (int i = 0; i < 4; i++) begin
         newcol[i] = b_kv_ff[i] ? rd[2'(b_rsel_ff + 2'(i))] : '0;
      end
      newcol[4] = b_val_ff;
      if (!take_b) begin
         newcol = '0;
      end
   end

   assign chain[5] = newcol;
   assign wt_mid = {2'd1, 2'd2, 2'd2, 2'd2, 2'd1};
   assign wt_ctr = {2'd1, 2'd2, 2'd3, 2'd2, 2'd1};

   for (genvar i = 0; i < 5; i++) begin : g_cell
      win_ctl_type cctl;
      always_comb begin
         cctl     = wctl;
         cctl.clr = (i == 4) ? 1'b0 : wctl.clr;
      end
      ibl_col_cell u_cell (
         .clock  (clock),
         .ctl    (cctl),
         .wt_mid (wt_mid[i]),
         .wt_ctr (wt_ctr[i]),
         .din    (chain[i+1]),
         .dout   (chain[i]),
         .sum    (csum[i])
      );
   end

   // flags along the pipeline: window, column sums, total, output
   logic w_emit_ff, w_emit_in, w_last_ff, w_last_in, w_fl_ff, w_fl_in;
   logic s1_emit_ff, s1_last_ff, s1_fl_ff;
   logic s2_emit_ff, s2_last_ff, s2_fl_ff;
   logic [2:0][13:0] s2_tot_ff, s2_tot_in;
   logic rsp_tvalid_ff;
   logic [23:0] rsp_tdata_ff, rsp_tdata_in;
   logic rsp_tlast_ff, rsp_tuser_ff;
   logic [2:0][28:0] prod;

   always_comb begin
      w_emit_in = 1'b0;
      w_last_in = 1'b0;
      w_fl_in   = 1'b0;
      if (take_b) begin
         w_emit_in = b_e0_ff;
         w_last_in = !b_er_ff;
         w_fl_in   = !b_er_ff && b_ef_ff;
      end else if (pend_ff == 2'd2) begin
         w_emit_in = q_e1_ff;
      end else if (pend_ff == 2'd1) begin
         w_emit_in = q_e2_ff;
         w_last_in = 1'b1;
         w_fl_in   = q_ef_ff;
      end
      for (int k = 0; k < 3; k++) begin
         s2_tot_in[k] = 14'(csum[0][k]) + 14'(csum[1][k]) + 14'(csum[2][k])
                      + 14'(csum[3][k]) + 14'(csum[4][k]);
         prod[k]      = 29'(s2_tot_ff[k]) * RECIP_35;
         rsp_tdata_in[8*k +: 8] = 8'd255 - prod[k][27:20];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_emit_ff     <= 1'b0;
         s1_emit_ff    <= 1'b0;
         s2_emit_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         w_emit_ff     <= w_emit_in;
         s1_emit_ff    <= w_emit_ff;
         s2_emit_ff    <= s1_emit_ff;
         rsp_tvalid_ff <= s2_emit_ff;
      end
      if (adv) begin
         w_last_ff    <= w_last_in;
         w_fl_ff      <= w_fl_in;
         s1_last_ff   <= w_last_ff;
         s1_fl_ff     <= w_fl_ff;
         s2_last_ff   <= s1_last_ff;
         s2_fl_ff     <= s1_fl_ff;
         s2_tot_ff    <= s2_tot_in;
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tlast_ff <= s2_last_ff;
         rsp_tuser_ff <= s2_fl_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   `IBL_ASSERT_IMPLY(a_fl_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast, "frame end without word end")
   `IBL_ASSERT_IMPLY(a_no_take, clock, reset, pend_ff != 2'd0 && b_vld_ff, !req_tready, "input taken while row end drains")
   `IBL_ASSERT_NEXT(a_pend, clock, reset, take_b && b_er_ff, pend_ff == 2'd2, "row end drain not started")
endmodule

// ===== tb/sv/inverted_blur5x5_rgb_stream_tb.sv =====
module inverted_blur5x5_rgb_stream_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ibl_pkg::*;

   localparam logic CMD_FLUSH = ~CMD_PIXEL;
   localparam int   DRAIN_CYCLES = 12;
   localparam int   CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [23:0] pix;
      logic        run_last;
      logic        frame_last;
   } blur_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = CMD_PIXEL;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = REG_FRAME_WIDTH;
   logic [12:0] csr_wdata = '0;

   inverted_blur5x5_rgb_stream DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [23:0]   line_mem [4*MAX_WIDTH];
   logic [23:0]   win [5][5];
   int            col_pos, row_pos, width_reg, height_reg;
   blur_word_type blur_expected [$];
   int            errors = 0, words_in = 0, words_out = 0, frames_done = 0;
   bit            idle_on = 1'b0;
   int            cycles = 0;

   function automatic void win_shift(logic [23:0] col [5]);
      for (int i = 0; i < 5; i++) begin
         for (int j = 0; j < 4; j++) win[i][j] = win[i][j+1];
         win[i][4] = col[i];
      end
   endfunction

   function automatic logic [23:0] blur_pixel();
      int s [3];
      int wt;
      logic [23:0] o;
      s = '{0, 0, 0};
      for (int i = 0; i < 5; i++)
         for (int j = 0; j < 5; j++) begin
            wt = (i == 2 && j == 2) ? 3 : (i == 0 || i == 4 || j == 0 || j == 4) ? 1 : 2;
            for (int k = 0; k < 3; k++) s[k] += wt * int'(win[i][j][8*k +: 8]);
         end
      for (int k = 0; k < 3; k++) o[8*k +: 8] = 8'(255 - s[k] / 35);
      return o;
   endfunction

   function automatic void blur_predict(logic cmd, logic [23:0] px);
      int w, h, c, r, n, k;
      logic [23:0] col [5];
      logic [23:0] zcol [5];
      logic [23:0] val;
      bit end_row, end_frame, rows_ok;
      blur_word_type res [3];
      w = width_reg; h = height_reg;
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (h < 1) h = 1;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      c = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
      r = row_pos;
      n = 0;
      zcol = '{default: '0};
      val = (cmd == CMD_PIXEL && r < h) ? px : '0;
      if (c == 0) win = '{default: '{default: '0}};
      for (int i = 0; i < 4; i++) begin
         k = r - 4 + i;
         col[i] = (k >= 0 && k < h) ? line_mem[((r + i) % 4) * MAX_WIDTH + c] : '0;
      end
      col[4] = val;
      line_mem[(r % 4) * MAX_WIDTH + c] = val;
      win_shift(col);
      end_row = (c + 1 >= w);
      end_frame = end_row && (r + 1 >= h + 2);
      rows_ok = (r >= 2) && (r - 2 < h);
      if (rows_ok && c >= 2) begin
         res[n] = '{blur_pixel(), 1'b0, 1'b0};
         n++;
      end
      if (end_row)
         for (int t = 1; t <= 2; t++) begin
            win_shift(zcol);
            if (rows_ok && c + t >= 2) begin
               res[n] = '{blur_pixel(), 1'b0, 1'b0};
               n++;
            end
         end
      if (n > 0) begin
         res[n-1].run_last = 1'b1;
         res[n-1].frame_last = end_frame;
      end
      for (int i = 0; i < n; i++) blur_expected.push_back(res[i]);
      if (end_row) begin
         col_pos = 0;
         row_pos = end_frame ? 0 : r + 1;
         if (end_frame) frames_done++;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   task automatic send_word(logic cmd, logic [23:0] px);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      blur_predict(cmd, px);
      words_in++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (blur_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [12:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      if (idx == REG_FRAME_WIDTH) width_reg = int'(v[11:0]);
      else height_reg = int'(v);
   endtask

   function automatic logic [23:0] pick_pixel(int mode);
      case (mode)
         0: return '0;
         1: return 24'hFFFFFF;
         2: return ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
         default: return 24'($urandom);
      endcase
   endfunction

   // noise: flush words inside the image, pixel words in the flush rows
   task automatic send_frame(logic [12:0] w_set, logic [12:0] h_set, int mode, bit noise);
      int w, h;
      wait_idle();
      csr_write(REG_FRAME_WIDTH, w_set);
      csr_write(REG_FRAME_HEIGHT, h_set);
      w = width_reg; h = height_reg;
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (h < 1) h = 1;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      for (int r = 0; r < h + 2; r++)
         for (int c = 0; c < w; c++)
            if (r < h)
               send_word((noise && $urandom_range(0, 9) == 0) ? CMD_FLUSH : CMD_PIXEL,
                         pick_pixel(mode));
            else
               send_word((noise && $urandom_range(0, 4) == 0) ? CMD_PIXEL : CMD_FLUSH,
                         pick_pixel(3));
      wait_idle();
   endtask

   task automatic test_extremes();
      idle_on = 1'b1;
      send_frame(13'd3, 13'd3, 1, 1'b0);
      send_frame(13'd3, 13'd2, 0, 1'b1);
      send_frame(13'd1, 13'd1, 2, 1'b0);
   endtask

   task automatic test_out_of_range();
      idle_on = 1'b0;
      send_frame(13'd0, 13'd0, 1, 1'b0);
      send_frame(13'd3, 13'd0, 3, 1'b0);
      send_frame(13'd0, 13'd3, 2, 1'b0);
   endtask

   task automatic test_random_frames(bit with_idle, int n_words);
      int start;
      idle_on = with_idle;
      start = words_in;
      while (words_in - start < n_words)
         send_frame(13'($urandom_range(1, 8)), 13'($urandom_range(1, 6)),
                    $urandom_range(0, 3), $urandom_range(0, 3) == 0);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   int stall_left = 0;
   always @(posedge clock) begin
      blur_word_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_out++;
         if (blur_expected.size() == 0) begin
            $display("%0t: unexpected word, actual %h last %b frame_last %b",
                     $time, rsp_tdata, rsp_tlast, rsp_tuser);
            errors++;
         end else begin
            e = blur_expected.pop_front();
            if (rsp_tdata !== e.pix || rsp_tlast !== e.run_last ||
                rsp_tuser !== e.frame_last) begin
               $display("%0t: mismatch, expected %h last %b frame_last %b, actual %h %b %b",
                        $time, e.pix, e.run_last, e.frame_last,
                        rsp_tdata, rsp_tlast, rsp_tuser);
               errors++;
            end
         end
      end
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (idle_on && $urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 11);
      end
   end

   initial begin
      for (int i = 0; i < 4*MAX_WIDTH; i++) line_mem[i] = '0;
      win = '{default: '{default: '0}};
      col_pos = 0; row_pos = 0;
      width_reg = int'(WIDTH_RST); height_reg = int'(HEIGHT_RST);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_out_of_range();
      test_random_frames(1'b1, 35);
      test_random_frames(1'b0, 15);
      wait_idle();
      if (blur_expected.size() != 0) errors++;
      $display("Covered %0d frames: %0d words in, %0d words out, extremes and zero sizes",
               frames_done, words_in, words_out);
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
